>>> design/ffck_pkg.sv
// Shared types and constants for the far-field cylindrical kernel.
// No dependencies.
package ffck_pkg;

	localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
	localparam logic [32:0] CORDIC_GAIN_Q30 = 33'h026DD3B6A;
	localparam int          CORDIC_STEPS    = 30;

	typedef enum logic [2:0] {
		REG_OBSERVER_X      = 3'd0,
		REG_OBSERVER_Z      = 3'd1,
		REG_FREQUENCY       = 3'd2,
		REG_SOURCE_X_OFFSET = 3'd3,
		REG_REFERENCE_Z     = 3'd4,
		REG_CELL_WIDTH_X    = 3'd5,
		REG_CELL_WIDTH_Z    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic               busy;
		logic signed [33:0] base_x;
		logic signed [45:0] dz;
		logic        [30:0] hx;
		logic        [31:0] freq;
		logic signed [33:0] row;
		logic        [31:0] snapped;
	} cfg_t;

	function automatic logic [32:0] atan_q30(input int i);
		logic [32:0] v;
		case (i)
			0:  v = 33'h03243F6A8;
			1:  v = 33'h01DAC6705;
			2:  v = 33'h00FADBAFC;
			3:  v = 33'h007F56EA6;
			4:  v = 33'h003FEAB76;
			5:  v = 33'h001FFD55B;
			6:  v = 33'h000FFFAAA;
			7:  v = 33'h0007FFF55;
			8:  v = 33'h0003FFFEA;
			9:  v = 33'h0001FFFFD;
			10: v = 33'h0000FFFFF;
			11: v = 33'h00007FFFF;
			12: v = 33'h00003FFFF;
			13: v = 33'h00001FFFF;
			14: v = 33'h00000FFFF;
			15: v = 33'h000007FFF;
			16: v = 33'h000003FFF;
			17: v = 33'h000001FFF;
			18: v = 33'h000000FFF;
			19: v = 33'h0000007FF;
			20: v = 33'h0000003FF;
			21: v = 33'h0000001FF;
			22: v = 33'h0000000FF;
			23: v = 33'h00000007F;
			24: v = 33'h00000003F;
			25: v = 33'h00000001F;
			26: v = 33'h00000000F;
			27: v = 33'h000000008;
			28: v = 33'h000000004;
			default: v = 33'h000000002;
		endcase
		return v;
	endfunction

endpackage

>>> design/far_field_cylindrical_kernel_top.sv
// Far-field cylindrical wave kernel: one grid point in, one kernel value out per beat.
// Throughput one beat per cycle when not held, set by the bit-per-stage root,
// CORDIC and divider pipelines. The whole pipeline holds while the output beat waits.
// A configuration write starts a pass that derives the reference row; no beat is taken
// during it. Reset clears the valid bits and returns the configuration registers to their reset values.
// Depends on ffck_pkg, ffck_cfg, ffck_sqrt, ffck_cordic, ffck_div.
module far_field_cylindrical_kernel_top import ffck_pkg::*; #(
	parameter int GRID_SIZE  = 4096,
	parameter int COMPONENTS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // grid_x_index[11:0], grid_z_index[23:12]
	input  logic [1:0]  s_axis_tuser,  // component[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // value_real[31:0], value_imag[63:32], snapped_reference_z[95:64]
	output logic        m_axis_tuser,  // on_reference_line[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg;
	logic en;
	logic [11:0] gx, gz;
	logic [1:0]  comp;
	logic        on_in;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_q;
	logic on_s1, on_s2, on_s3, on_s4, on_s5, on_s6, on_s7, on_s8, on_s9, on_s10, on_s11;
	logic [43:0] mx_s1;
	logic signed [45:0] dx_s2;
	logic [44:0] ax_s3, az_s3;
	logic [63:0] pxll_s4, pzll_s4;
	logic [44:0] pxlh_s4, pzlh_s4;
	logic [25:0] pxhh_s4, pzhh_s4;
	logic [89:0] sqx_s5, sqz_s5;
	logic [90:0] n_s6;
	logic [63:0] frl_s7;
	logic [45:0] frh_s7;
	logic [31:0] s_s7, s_s8, s_s9, s_s10, s_s11;
	logic [31:0] p_s8;
	logic [30:0] ang_s9;
	logic [1:0]  quad_s9;
	logic signed [32:0] c_s10, sn_s10;
	logic [45:0] mre_s11, mim_s11;
	logic        nre_s11, zre_s11, nim_s11, zim_s11;
	logic [31:0] re_q, im_q;
	logic        on_q;

	logic        r_vld, r_on;
	logic [45:0] r_w;
	logic        s_vld;
	logic [46:0] s_side;
	logic [31:0] s_w;
	logic        k_vld;
	logic [34:0] k_side;
	logic signed [32:0] k_cos, k_sin;
	logic        d_vld;
	logic [4:0]  d_side;
	logic [45:0] q_re, q_im;
	logic [32:0] mc, ms;
	logic [31:0] re_w, im_w;

	ffck_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en            = !vld_q || m_axis_tready;
	assign s_axis_tready = en && !cfg.busy;
	assign gx            = s_axis_tdata[11:0];
	assign gz            = s_axis_tdata[23:12];
	assign comp          = s_axis_tuser;
	assign on_in = (32'(gx) < GRID_SIZE) && (32'(gz) < GRID_SIZE) && (32'(comp) < COMPONENTS)
		&& (comp == 2'd1) && (cfg.row == $signed({22'd0, gz}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6} <= '0;
			{vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_q} <= '0;
		end else if (en) begin
			vld_s1  <= s_axis_tvalid && !cfg.busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= s_vld;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= k_vld;
			vld_s11 <= vld_s10;
			vld_q   <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			on_s1   <= on_in;
			mx_s1   <= {gx, 1'b1} * cfg.hx;
			on_s2   <= on_s1;
			dx_s2   <= $signed({{12{cfg.base_x[33]}}, cfg.base_x}) - $signed({2'b00, mx_s1});
			on_s3   <= on_s2;
			ax_s3   <= dx_s2[45] ? 45'(-dx_s2) : dx_s2[44:0];
			az_s3   <= cfg.dz[45] ? 45'(-cfg.dz) : cfg.dz[44:0];
			on_s4   <= on_s3;
			pxll_s4 <= ax_s3[31:0] * ax_s3[31:0];
			pxlh_s4 <= ax_s3[44:32] * ax_s3[31:0];
			pxhh_s4 <= ax_s3[44:32] * ax_s3[44:32];
			pzll_s4 <= az_s3[31:0] * az_s3[31:0];
			pzlh_s4 <= az_s3[44:32] * az_s3[31:0];
			pzhh_s4 <= az_s3[44:32] * az_s3[44:32];
			on_s5   <= on_s4;
			sqx_s5  <= {pxhh_s4, 64'd0} + {12'd0, pxlh_s4, 33'd0} + {26'd0, pxll_s4};
			sqz_s5  <= {pzhh_s4, 64'd0} + {12'd0, pzlh_s4, 33'd0} + {26'd0, pzll_s4};
			on_s6   <= on_s5;
			n_s6    <= {1'b0, sqx_s5} + {1'b0, sqz_s5};
		end
	end

	ffck_sqrt #(.IN_W(92), .OUT_W(46), .SIDE_W(1)) u_root_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_side   (on_s6),
		.radicand  ({1'b0, n_s6}),
		.out_valid (r_vld),
		.out_side  (r_on),
		.root      (r_w)
	);

	ffck_sqrt #(.IN_W(64), .OUT_W(32), .SIDE_W(47)) u_root_s (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_vld),
		.in_side   ({r_on, r_w}),
		.radicand  ({1'b0, r_w, 17'd0}),
		.out_valid (s_vld),
		.out_side  (s_side),
		.root      (s_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			on_s7   <= s_side[46];
			s_s7    <= s_w;
			frl_s7  <= cfg.freq * s_side[31:0];
			frh_s7  <= cfg.freq * s_side[45:32];
			on_s8   <= on_s7;
			s_s8    <= s_s7;
			p_s8    <= 32'((frl_s7[44:0] + {frh_s7[12:0], 32'd0}) >> 13);
			on_s9   <= on_s8;
			s_s9    <= s_s8;
			quad_s9 <= p_s8[31:30];
			ang_s9  <= 31'(({31'd0, p_s8[29:0]} * {30'd0, HALF_PI_Q30}) >> 30);
		end
	end

	ffck_cordic #(.SIDE_W(35)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s9),
		.in_side   ({on_s9, quad_s9, s_s9}),
		.angle     (ang_s9),
		.out_valid (k_vld),
		.out_side  (k_side),
		.cos_q     (k_cos),
		.sin_q     (k_sin)
	);

	assign mc = c_s10[32] ? 33'(-c_s10) : c_s10;
	assign ms = sn_s10[32] ? 33'(-sn_s10) : sn_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			on_s10 <= k_side[34];
			s_s10  <= k_side[31:0];
			case (k_side[33:32])
				2'd0: begin
					c_s10  <= k_cos;
					sn_s10 <= k_sin;
				end
				2'd1: begin
					c_s10  <= -k_sin;
					sn_s10 <= k_cos;
				end
				2'd2: begin
					c_s10  <= -k_cos;
					sn_s10 <= -k_sin;
				end
				default: begin
					c_s10  <= k_sin;
					sn_s10 <= -k_cos;
				end
			endcase
			on_s11  <= on_s10;
			s_s11   <= s_s10;
			mre_s11 <= {mc, 13'd0};
			mim_s11 <= {ms, 13'd0};
			nre_s11 <= c_s10[32];
			zre_s11 <= c_s10 == 33'sd0;
			nim_s11 <= !sn_s10[32] && sn_s10 != 33'sd0;
			zim_s11 <= sn_s10 == 33'sd0;
		end
	end

	ffck_div #(.NUM_W(46), .DEN_W(32), .SIDE_W(5)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s11),
		.in_side   ({on_s11, nre_s11, zre_s11, nim_s11, zim_s11}),
		.num_a     (mre_s11),
		.num_b     (mim_s11),
		.den       (s_s11),
		.out_valid (d_vld),
		.out_side  (d_side),
		.quo_a     (q_re),
		.quo_b     (q_im)
	);

	always_comb begin
		if (!d_side[4] || d_side[2])         re_w = '0;
		else if (d_side[3])                  re_w = (q_re >= 46'h80000000) ? 32'h80000000
			: 32'(32'd0 - q_re[31:0]);
		else                                 re_w = (q_re > 46'h7FFFFFFF) ? 32'h7FFFFFFF
			: q_re[31:0];
		if (!d_side[4] || d_side[0])         im_w = '0;
		else if (d_side[1])                  im_w = (q_im >= 46'h80000000) ? 32'h80000000
			: 32'(32'd0 - q_im[31:0]);
		else                                 im_w = (q_im > 46'h7FFFFFFF) ? 32'h7FFFFFFF
			: q_im[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q <= re_w;
			im_q <= im_w;
			on_q <= d_side[4];
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = {cfg.snapped, im_q, re_q};
	assign m_axis_tuser  = on_q;

endmodule

>>> design/ffck_cfg.sv
// Configuration registers and derived per-setting terms (reference row, snapped height).
// Depends on ffck_pkg.
module ffck_cfg import ffck_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_FIX  = 4'b0100,
		ST_MUL  = 4'b1000
	} state_t;

	state_t state_q;
	logic [31:0] obs_x_q, obs_z_q, freq_q, off_q, ref_z_q;
	logic [30:0] cwx_q, cwz_q;
	logic [31:0] dq_q;
	logic [30:0] rem_q;
	logic [4:0]  cnt_q;
	logic signed [33:0] row_q, base_x_q;
	logic signed [45:0] dz_q;
	logic [31:0] snapped_q;

	logic        wr;
	logic [30:0] hx, hz;
	logic [31:0] ref_mag;
	logic [31:0] trial;
	logic        ge;
	logic        neg, rem_nz;
	logic signed [33:0] row_n, snap_w;
	logic [30:0] mod_n;
	logic [43:0] row_term;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;
	assign hx        = (cwx_q == 31'd0) ? 31'd1 : cwx_q;
	assign hz        = (cwz_q == 31'd0) ? 31'd1 : cwz_q;
	assign neg       = ref_z_q[31];
	assign ref_mag   = neg ? (32'd0 - ref_z_q) : ref_z_q;
	assign trial     = {rem_q, (cnt_q == 5'd0) ? ref_mag[31] : dq_q[31]};
	assign ge        = trial >= {1'b0, hz};
	assign rem_nz    = rem_q != 31'd0;

	always_comb begin
		if (neg) begin
			row_n = rem_nz ? (-$signed({2'b00, dq_q}) - 34'sd1) : -$signed({2'b00, dq_q});
			mod_n = rem_nz ? (hz - rem_q) : 31'd0;
		end else begin
			row_n = $signed({2'b00, dq_q});
			mod_n = rem_q;
		end
		snap_w = $signed({{2{ref_z_q[31]}}, ref_z_q}) - $signed({3'b000, mod_n})
			+ $signed({4'b0000, hz[30:1]});
	end

	assign row_term = {row_q[11:0], 1'b1} * hz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_x_q <= '0;
			obs_z_q <= '0;
			freq_q  <= '0;
			off_q   <= '0;
			ref_z_q <= '0;
			cwx_q   <= 31'd1048576;
			cwz_q   <= 31'd1048576;
		end else if (wr) begin
			case (cfg_index)
				REG_OBSERVER_X:      obs_x_q <= cfg_data;
				REG_OBSERVER_Z:      obs_z_q <= cfg_data;
				REG_FREQUENCY:       freq_q  <= cfg_data;
				REG_SOURCE_X_OFFSET: off_q   <= cfg_data;
				REG_REFERENCE_Z:     ref_z_q <= cfg_data;
				REG_CELL_WIDTH_X:    cwx_q   <= cfg_data[30:0];
				REG_CELL_WIDTH_Z:    cwz_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			dq_q      <= '0;
			rem_q     <= '0;
			row_q     <= '0;
			base_x_q  <= '0;
			dz_q      <= -46'sd1048576;
			snapped_q <= 32'd524288;
		end else if (wr) begin
			state_q <= ST_DIV;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: ;
				ST_DIV: begin
					rem_q <= ge ? 31'(trial - {1'b0, hz}) : trial[30:0];
					dq_q  <= {(cnt_q == 5'd0) ? ref_mag[30:0] : dq_q[30:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= ST_FIX;
				end
				ST_FIX: begin
					row_q    <= row_n;
					base_x_q <= $signed({obs_x_q[31], obs_x_q, 1'b0})
						- $signed({off_q[31], off_q, 1'b0});
					if (snap_w > 34'sd2147483647)        snapped_q <= 32'h7FFFFFFF;
					else if (snap_w < -34'sd2147483648)  snapped_q <= 32'h80000000;
					else                                 snapped_q <= snap_w[31:0];
					state_q  <= ST_MUL;
				end
				ST_MUL: begin
					dz_q    <= $signed({{13{obs_z_q[31]}}, obs_z_q, 1'b0}) - $signed({2'b00, row_term});
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg.busy    = state_q != ST_IDLE;
	assign cfg.base_x  = base_x_q;
	assign cfg.dz      = dz_q;
	assign cfg.hx      = hx;
	assign cfg.freq    = freq_q;
	assign cfg.row     = row_q;
	assign cfg.snapped = snapped_q;

endmodule

>>> design/ffck_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband carried alongside.
// No dependencies.
module ffck_sqrt #(
	parameter int IN_W   = 92,
	parameter int OUT_W  = 46,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SIDE_W-1:0] in_side,
	input  logic [IN_W-1:0]   radicand,
	output logic              out_valid,
	output logic [SIDE_W-1:0] out_side,
	output logic [OUT_W-1:0]  root
);

	localparam int W = IN_W + 1;

	logic [W-1:0]      rem_s  [OUT_W];
	logic [OUT_W-1:0]  res_s  [OUT_W];
	logic [SIDE_W-1:0] side_s [OUT_W];
	logic              vld_s  [OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		localparam int B = OUT_W - 1 - k;
		logic [W-1:0]      rem_i, trial;
		logic [OUT_W-1:0]  res_i;
		logic [SIDE_W-1:0] side_i;
		logic              vld_i;
		if (k == 0) begin : g_first
			assign rem_i  = {1'b0, radicand};
			assign res_i  = '0;
			assign side_i = in_side;
			assign vld_i  = in_valid;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign res_i  = res_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end
		assign trial = (W'(res_i) << (B + 1)) | (W'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= (rem_i >= trial) ? (rem_i - trial) : rem_i;
				res_s[k]  <= (rem_i >= trial) ? (res_i | (OUT_W'(1) << B)) : res_i;
				side_s[k] <= side_i;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_i;
		end
	end

	assign out_valid = vld_s[OUT_W-1];
	assign out_side  = side_s[OUT_W-1];
	assign root      = res_s[OUT_W-1];

endmodule

>>> design/ffck_cordic.sv
// Pipelined rotation CORDIC, one micro-rotation per stage, Q2.30 cosine and sine.
// Depends on ffck_pkg.
module ffck_cordic import ffck_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [SIDE_W-1:0]  in_side,
	input  logic [30:0]        angle,
	output logic               out_valid,
	output logic [SIDE_W-1:0]  out_side,
	output logic signed [32:0] cos_q,
	output logic signed [32:0] sin_q
);

	logic signed [32:0] x_s [CORDIC_STEPS];
	logic signed [32:0] y_s [CORDIC_STEPS];
	logic signed [32:0] z_s [CORDIC_STEPS];
	logic [SIDE_W-1:0]  side_s [CORDIC_STEPS];
	logic               vld_s  [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic signed [32:0] x_i, y_i, z_i, xs, ys, at;
		logic [SIDE_W-1:0]  side_i;
		logic               vld_i;
		if (i == 0) begin : g_first
			assign x_i    = $signed(CORDIC_GAIN_Q30);
			assign y_i    = '0;
			assign z_i    = $signed({2'b00, angle});
			assign side_i = in_side;
			assign vld_i  = in_valid;
		end else begin : g_next
			assign x_i    = x_s[i-1];
			assign y_i    = y_s[i-1];
			assign z_i    = z_s[i-1];
			assign side_i = side_s[i-1];
			assign vld_i  = vld_s[i-1];
		end
		assign xs = x_i >>> i;
		assign ys = y_i >>> i;
		assign at = $signed(atan_q30(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_i[32]) begin
					x_s[i] <= x_i - ys;
					y_s[i] <= y_i + xs;
					z_s[i] <= z_i - at;
				end else begin
					x_s[i] <= x_i + ys;
					y_s[i] <= y_i - xs;
					z_s[i] <= z_i + at;
				end
				side_s[i] <= side_i;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i] <= 1'b0;
			else if (en) vld_s[i] <= vld_i;
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];
	assign cos_q     = x_s[CORDIC_STEPS-1];
	assign sin_q     = y_s[CORDIC_STEPS-1];

endmodule

>>> design/ffck_div.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
// No dependencies.
module ffck_div #(
	parameter int NUM_W  = 46,
	parameter int DEN_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SIDE_W-1:0] in_side,
	input  logic [NUM_W-1:0]  num_a,
	input  logic [NUM_W-1:0]  num_b,
	input  logic [DEN_W-1:0]  den,
	output logic              out_valid,
	output logic [SIDE_W-1:0] out_side,
	output logic [NUM_W-1:0]  quo_a,
	output logic [NUM_W-1:0]  quo_b
);

	logic [DEN_W-1:0]  ra_s [NUM_W];
	logic [DEN_W-1:0]  rb_s [NUM_W];
	logic [NUM_W-1:0]  qa_s [NUM_W];
	logic [NUM_W-1:0]  qb_s [NUM_W];
	logic [DEN_W-1:0]  d_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];
	logic              vld_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0]  ra_i, rb_i, d_i;
		logic [NUM_W-1:0]  qa_i, qb_i;
		logic [SIDE_W-1:0] side_i;
		logic              vld_i;
		logic [DEN_W:0]    ta, tb;
		logic              gea, geb;
		if (k == 0) begin : g_first
			assign ra_i   = '0;
			assign rb_i   = '0;
			assign qa_i   = num_a;
			assign qb_i   = num_b;
			assign d_i    = den;
			assign side_i = in_side;
			assign vld_i  = in_valid;
		end else begin : g_next
			assign ra_i   = ra_s[k-1];
			assign rb_i   = rb_s[k-1];
			assign qa_i   = qa_s[k-1];
			assign qb_i   = qb_s[k-1];
			assign d_i    = d_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end
		assign ta  = {ra_i, qa_i[NUM_W-1]};
		assign tb  = {rb_i, qb_i[NUM_W-1]};
		assign gea = ta >= {1'b0, d_i};
		assign geb = tb >= {1'b0, d_i};
		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k]   <= gea ? DEN_W'(ta - {1'b0, d_i}) : ta[DEN_W-1:0];
				rb_s[k]   <= geb ? DEN_W'(tb - {1'b0, d_i}) : tb[DEN_W-1:0];
				qa_s[k]   <= {qa_i[NUM_W-2:0], gea};
				qb_s[k]   <= {qb_i[NUM_W-2:0], geb};
				d_s[k]    <= d_i;
				side_s[k] <= side_i;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_i;
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];
	assign quo_a     = qa_s[NUM_W-1];
	assign quo_b     = qb_s[NUM_W-1];

endmodule

>>> verif/tb_far_field_cylindrical_kernel_top.sv
// Self-checking testbench for far_field_cylindrical_kernel_top: streams grid points,
// predicts each kernel value in fixed point and checks every output beat.
// Depends on ffck_pkg and the block's RTL.
module tb_far_field_cylindrical_kernel_top;
	import ffck_pkg::*;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               on;
		logic signed [31:0] snap;
	} kern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic signed [31:0] obs_x = 0, obs_z = 0, src_off = 0, ref_z = 0;
	logic        [31:0] freq = 0;
	logic        [30:0] cw_x = 31'd1048576, cw_z = 31'd1048576;

	kern_t pending_values[$];
	int    errors = 0;
	bit    calm = 0;

	far_field_cylindrical_kernel_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_to_q24(longint c, logic [63:0] s);
		longint num;
		logic [63:0] q;
		num = c * 8192;
		if (s == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
		q = mag(num) / s;
		if (q > 64'h80000000) q = 64'h80000000;
		return sat32(num < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint reference_row();
		longint hz, rz, row;
		hz = cw_z == 0 ? 1 : longint'({33'b0, cw_z});
		rz = ref_z;
		row = rz / hz;
		if (rz % hz != 0 && rz < 0) row--;
		return row;
	endfunction

	function automatic kern_t kernel_value(logic [11:0] gx, logic [11:0] gz, logic [1:0] comp);
		longint hx, hz, row, ox, oz, dx, dz, x, y, z, xs, ys, c, sn;
		logic [127:0] sq, a, b, cw;
		logic [63:0] r, s, p, ang, cand, prod, f64;
		kern_t k;
		hx = cw_x == 0 ? 1 : longint'({33'b0, cw_x});
		hz = cw_z == 0 ? 1 : longint'({33'b0, cw_z});
		row = reference_row();
		k.snap = 32'(sat32(row * hz + (hz >>> 1)));
		k.on = comp == 2'd1 && longint'({52'b0, gz}) == row;
		k.re = 0;
		k.im = 0;
		if (k.on) begin
			ox = obs_x;
			oz = obs_z;
			dx = 2 * ox - 2 * longint'(src_off) - (2 * longint'({52'b0, gx}) + 1) * hx;
			dz = 2 * oz - (2 * row + 1) * hz;
			a = mag(dx);
			b = mag(dz);
			sq = a * a + b * b;
			r = 0;
			for (int i = 46; i >= 0; i--) begin
				cand = r | (64'd1 << i);
				cw = cand;
				if (cw * cw <= sq) r = cand;
			end
			s = 0;
			for (int i = 31; i >= 0; i--) begin
				cand = s | (64'd1 << i);
				if (cand * cand <= (r << 17)) s = cand;
			end
			f64 = freq;
			prod = f64 * r;
			p = (prod >> 13) & 64'hFFFFFFFF;
			ang = ((p & 64'h3FFFFFFF) * 64'(HALF_PI_Q30)) >> 30;
			x = longint'(CORDIC_GAIN_Q30);
			y = 0;
			z = longint'(ang);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= longint'(atan_q30(i));
				end else begin
					x += ys; y -= xs; z += longint'(atan_q30(i));
				end
			end
			case (p[31:30])
				2'd0: begin c = x; sn = y; end
				2'd1: begin c = -y; sn = x; end
				2'd2: begin c = -x; sn = -y; end
				default: begin c = y; sn = -x; end
			endcase
			k.re = 32'(scale_to_q24(c, s));
			k.im = 32'(scale_to_q24(-sn, s));
		end
		return k;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		kern_t e;
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_values.size() == 0) begin
				report("unexpected beat", m_axis_tdata[31:0], 0);
			end else begin
				e = pending_values.pop_front();
				if (m_axis_tdata[31:0] !== e.re) report("value_real", m_axis_tdata[31:0], e.re);
				if (m_axis_tdata[63:32] !== e.im) report("value_imag", m_axis_tdata[63:32], e.im);
				if (m_axis_tuser !== e.on) report("on_reference_line", m_axis_tuser, e.on);
				if (m_axis_tdata[95:64] !== e.snap)
					report("snapped_reference_z", m_axis_tdata[95:64], e.snap);
			end
		end
	end

	task automatic send_point(logic [11:0] gx, logic [11:0] gz, logic [1:0] comp);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 37 && gap < 8) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {gz, gx};
		s_axis_tuser <= comp;
		do @(posedge clk); while (!s_axis_tready);
		pending_values.push_back(kernel_value(gx, gz, comp));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_values.size() != 0) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OBSERVER_X:      obs_x = v;
			REG_OBSERVER_Z:      obs_z = v;
			REG_FREQUENCY:       freq = v;
			REG_SOURCE_X_OFFSET: src_off = v;
			REG_REFERENCE_Z:     ref_z = v;
			REG_CELL_WIDTH_X:    cw_x = v[30:0];
			default:             cw_z = v[30:0];
		endcase
	endtask

	task automatic end_cfg();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_values();
		send_point(12'd0, 12'd0, 2'd1);
		send_point(12'd4095, 12'd0, 2'd1);
		send_point(12'd0, 12'd0, 2'd0);
		send_point(12'd0, 12'd0, 2'd2);
		send_point(12'd0, 12'd0, 2'd3);
		send_point(12'd5, 12'd1, 2'd1);
		send_point(12'd4095, 12'd4095, 2'd1);
		send_point(12'hAAA, 12'h555, 2'd3);
		drain();
	endtask

	task automatic test_zero_distance();
		set_reg(REG_OBSERVER_X, 32'h00080000);
		set_reg(REG_OBSERVER_Z, 32'h00080000);
		set_reg(REG_FREQUENCY, 32'h01000000);
		end_cfg();
		send_point(12'd0, 12'd0, 2'd1);
		send_point(12'd1, 12'd0, 2'd1);
		drain();
	endtask

	task automatic test_extreme_registers();
		set_reg(REG_OBSERVER_X, 32'h7FFFFFFF);
		set_reg(REG_OBSERVER_Z, 32'h80000000);
		set_reg(REG_FREQUENCY, 32'hFFFFFFFF);
		set_reg(REG_SOURCE_X_OFFSET, 32'h80000000);
		set_reg(REG_CELL_WIDTH_X, 32'hFFFFFFFF);
		set_reg(REG_CELL_WIDTH_Z, 32'h7FFFFFFF);
		set_reg(REG_REFERENCE_Z, 32'h7FFFFFFF);
		end_cfg();
		send_point(12'd4095, 12'd1, 2'd1);
		send_point(12'd0, 12'd0, 2'd1);
		drain();
		set_reg(REG_CELL_WIDTH_X, 32'h0);
		set_reg(REG_CELL_WIDTH_Z, 32'h0);
		set_reg(REG_REFERENCE_Z, 32'd100);
		set_reg(REG_SOURCE_X_OFFSET, 32'h7FFFFFFF);
		end_cfg();
		send_point(12'd0, 12'd100, 2'd1);
		send_point(12'd4095, 12'd100, 2'd1);
		drain();
		set_reg(REG_REFERENCE_Z, 32'hFFFFFFFF);
		end_cfg();
		send_point(12'd0, 12'd0, 2'd1);
		send_point(12'd4095, 12'd4095, 2'd1);
		drain();
		set_reg(REG_CELL_WIDTH_Z, 32'd1);
		set_reg(REG_REFERENCE_Z, 32'd4096);
		end_cfg();
		send_point(12'd7, 12'd4095, 2'd1);
		send_point(12'd7, 12'd0, 2'd1);
		drain();
	endtask

	task automatic test_random_phase(int n, bit quiet, bit hold_mid);
		int unsigned hz;
		longint row;
		calm = quiet;
		hz = $urandom_range(1, (1 << 19) - 1);
		set_reg(REG_CELL_WIDTH_Z, hz);
		set_reg(REG_CELL_WIDTH_X, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 21));
		set_reg(REG_REFERENCE_Z, $urandom_range(0, 7) == 0 ? $urandom :
			$urandom_range(0, 4095) * hz + $urandom_range(0, hz - 1));
		set_reg(REG_OBSERVER_X, $urandom);
		set_reg(REG_OBSERVER_Z, $urandom);
		set_reg(REG_FREQUENCY, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 26));
		set_reg(REG_SOURCE_X_OFFSET, $urandom);
		end_cfg();
		row = reference_row();
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2) drain();
			if (row >= 0 && row < 4096 && $urandom_range(99) < 75)
				send_point(12'($urandom), 12'(row), 2'd1);
			else
				send_point(12'($urandom), 12'($urandom), 2'($urandom_range(0, 3)));
		end
		drain();
		calm = 0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_zero_distance();
		test_extreme_registers();
		for (int ph = 0; ph < 10; ph++)
			test_random_phase(115, ph == 3, ph == 6);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[far_field_cylindrical_kernel_top] OK");
		else
			$display("[far_field_cylindrical_kernel_top] ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("[far_field_cylindrical_kernel_top] ERROR");
		$finish;
	end

endmodule
